// ===== rtl/great_circle_distance_assert.svh =====
// Assertion macros shared by the great-circle distance checker.
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// Overlapping implication, checked at each rising clock edge outside reset.
`define GCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("great_circle_distance: implication check failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define GCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("great_circle_distance: next-cycle check failed");

`endif

// ===== rtl/gcd_pkg.sv =====
// Types, constants and arithmetic helpers for the great-circle distance pipeline.
`default_nettype none

package gcd_pkg;

   // Fixed-point formats.
   localparam int ANGLE_FRAC_BITS = 20;
   localparam int CORDIC_STEPS    = 30;
   localparam int Q_FRAC          = 30;
   localparam int SQRT_STEPS      = Q_FRAC + 1;
   localparam int SQ_VW           = 2 * Q_FRAC + 1;
   localparam int SQ_RW           = 2 * Q_FRAC + 2;
   localparam int CW              = 34;

   // Latency from the accepting edge to the edge that takes the result.
   localparam int PIPE_LAT = 4 + CORDIC_STEPS + 4 + SQRT_STEPS + CORDIC_STEPS + 2;

   typedef logic signed [CW-1:0] cval_type;

   typedef enum logic [1:0] {
      CORDIC_ROTATE = 2'b01,
      CORDIC_VECTOR = 2'b10
   } cordic_mode_type;

   // Coordinate limits in scaled degrees.
   localparam logic signed [27:0] LAT_LIM = 28'(90 <<< ANGLE_FRAC_BITS);
   localparam logic signed [28:0] LON_LIM = 29'(180 <<< ANGLE_FRAC_BITS);

   // Constants: angles and the gain in Q30, the degree-to-radian factor in Q32.
   localparam logic signed [27:0] DEG2RAD_K32 = 28'sd74961321;
   localparam cval_type           GAIN_INV    = 34'sd652032874;
   localparam logic [32:0]        HALF_PI_Q30 = 33'd1686629713;
   localparam logic [32:0]        PI_Q30      = 33'd3373259426;
   localparam logic [30:0]        ONE_Q30     = 31'd1 << Q_FRAC;
   localparam logic [24:0]        SPAN_MAX    = 25'h1FFFFFF;
   localparam logic [23:0]        RADIUS_RST  = 24'd6378000;

   localparam cval_type ATAN_HEAD [10] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
      34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149
   };

   // Arctangent of 2^-i in Q30.
   function automatic cval_type atan_q30(input int i);
      cval_type val;
      if (i < 10) begin
         val = ATAN_HEAD[i];
      end else if (i <= Q_FRAC) begin
         val = cval_type'(34'sd1 <<< (Q_FRAC - i));
      end else begin
         val = '0;
      end
      return val;
   endfunction

   // Rounds a Q60 product back to Q30, half away from zero.
   function automatic cval_type rnd_q30(input logic signed [67:0] v);
      logic [67:0] mag;
      mag = v[67] ? 68'(-v) : 68'(v);
      mag = (mag + (68'd1 << (Q_FRAC - 1))) >> Q_FRAC;
      return v[67] ? cval_type'(-$signed(mag)) : cval_type'($signed(mag));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gcd_cordic.sv =====
// Unrolled CORDIC pipeline, one register stage per iteration, rotation or vectoring.
`default_nettype none

module gcd_cordic (
   input  logic                    clock,
   input  gcd_pkg::cordic_mode_type mode,
   input  gcd_pkg::cval_type       x_start,
   input  gcd_pkg::cval_type       y_start,
   input  gcd_pkg::cval_type       z_start,
   output gcd_pkg::cval_type       x_end,
   output gcd_pkg::cval_type       y_end,
   output gcd_pkg::cval_type       z_end
);
   import gcd_pkg::*;

   cval_type x_ff [CORDIC_STEPS];
   cval_type y_ff [CORDIC_STEPS];
   cval_type z_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      cval_type xs, ys, zs;
      cval_type x_step_in, y_step_in, z_step_in;
      logic     up;

      // The first stage takes the inputs, later ones the previous stage.
      if (i == 0) begin : g_first
         assign xs = x_start;
         assign ys = y_start;
         assign zs = z_start;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end

      // Rotation steers on the residual angle, vectoring on the sign of y.
      always_comb begin
         up = (mode == CORDIC_ROTATE) ? !zs[CW-1] : ys[CW-1];
         if (up) begin
            x_step_in = xs - (ys >>> i);
            y_step_in = ys + (xs >>> i);
            z_step_in = zs - atan_q30(i);
         end else begin
            x_step_in = xs + (ys >>> i);
            y_step_in = ys - (xs >>> i);
            z_step_in = zs + atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i] <= x_step_in;
         y_ff[i] <= y_step_in;
         z_ff[i] <= z_step_in;
      end
   end

   assign x_end = x_ff[CORDIC_STEPS-1];
   assign y_end = y_ff[CORDIC_STEPS-1];
   assign z_end = z_ff[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/gcd_sqrt.sv =====
// Pipelined bit-by-bit square root of a Q30 value, giving a Q30 root.
`default_nettype none

module gcd_sqrt (
   input  logic                     clock,
   input  logic [gcd_pkg::Q_FRAC:0] value,
   output logic [gcd_pkg::Q_FRAC:0] root
);
   import gcd_pkg::*;

   logic [SQ_VW-1:0] v_ff [SQRT_STEPS];
   logic [SQ_RW-1:0] r_ff [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [SQ_RW-1:0] BIT = SQ_RW'(1) << (2 * Q_FRAC - 2 * j);
      logic [SQ_VW-1:0] vs, v_step_in;
      logic [SQ_RW-1:0] rs, r_step_in, trial;

      if (j == 0) begin : g_first
         assign vs = {value, Q_FRAC'(0)};
         assign rs = '0;
      end else begin : g_next
         assign vs = v_ff[j-1];
         assign rs = r_ff[j-1];
      end

      // Subtract the trial term when it fits and set this root bit.
      always_comb begin
         trial = rs + BIT;
         if ({1'b0, vs} >= trial) begin
            v_step_in = vs - trial[SQ_VW-1:0];
            r_step_in = (rs >> 1) + BIT;
         end else begin
            v_step_in = vs;
            r_step_in = rs >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[j] <= v_step_in;
         r_ff[j] <= r_step_in;
      end
   end

   assign root = r_ff[SQRT_STEPS-1][Q_FRAC:0];

endmodule

`default_nettype wire

// ===== rtl/great_circle_distance.sv =====
// Top level of the pipelined haversine great-circle distance unit.
//
//   Channel   Ports                            Handshake
//   request   start, busy, req_*               taken when start && !busy
//   result    rsp_valid, rsp_span_m            one-cycle strobe, no backpressure
//   config    csr_valid, csr_ready, csr_wdata  written when csr_valid && csr_ready
//
// A new item can enter in every cycle; busy is always low.
// Each result passes through four input stages, a 30-step sin/cos CORDIC, four
// product stages, a 31-step square root, a 30-step atan2 CORDIC and two scaling
// stages.
// Reset is synchronous; it clears the valid pipe and loads the radius register with its reset value.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module great_circle_distance (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [27:0] req_src_lat,
   input  logic signed [28:0] req_src_lon,
   input  logic signed [27:0] req_dst_lat,
   input  logic signed [28:0] req_dst_lon,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [24:0]        rsp_span_m
);
   import gcd_pkg::*;

   logic [PIPE_LAT-1:0] valid_ff, valid_in;
   logic [23:0]         radius_ff, radius_in;

   // Handshakes: always ready on both the request and the config channel.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      valid_in  = {valid_ff[PIPE_LAT-2:0], start && !busy};
      radius_in = (csr_valid && csr_ready) ? csr_wdata : radius_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         radius_ff <= RADIUS_RST;
      end else begin
         valid_ff  <= valid_in;
         radius_ff <= radius_in;
      end
   end

   // Stage 0: saturate the coordinates and take the differences.
   logic signed [27:0] lat1_in, lat2_in, lat1_ff, lat2_ff;
   logic signed [28:0] lon1_in, lon2_in;
   logic signed [28:0] dlat_ff;
   logic signed [29:0] dlon_ff;

   always_comb begin
      lat1_in = (req_src_lat > LAT_LIM) ? LAT_LIM :
                (req_src_lat < -LAT_LIM) ? -LAT_LIM : req_src_lat;
      lat2_in = (req_dst_lat > LAT_LIM) ? LAT_LIM :
                (req_dst_lat < -LAT_LIM) ? -LAT_LIM : req_dst_lat;
      lon1_in = (req_src_lon > LON_LIM) ? LON_LIM :
                (req_src_lon < -LON_LIM) ? -LON_LIM : req_src_lon;
      lon2_in = (req_dst_lon > LON_LIM) ? LON_LIM :
                (req_dst_lon < -LON_LIM) ? -LON_LIM : req_dst_lon;
   end

   always_ff @(posedge clock) begin
      lat1_ff <= lat1_in;
      lat2_ff <= lat2_in;
      dlat_ff <= 29'(lat2_in) - 29'(lat1_in);
      dlon_ff <= 30'(lon2_in) - 30'(lon1_in);
   end

   // Stage 1: scale to radians with one multiplier per angle.
   logic signed [57:0] p_hlat_ff, p_hlon_ff, p_r1_ff, p_r2_ff;

   always_ff @(posedge clock) begin
      p_hlat_ff <= 58'(dlat_ff) * 58'(DEG2RAD_K32);
      p_hlon_ff <= 58'(dlon_ff) * 58'(DEG2RAD_K32);
      p_r1_ff   <= 58'(lat1_ff) * 58'(DEG2RAD_K32);
      p_r2_ff   <= 58'(lat2_ff) * 58'(DEG2RAD_K32);
   end

   // Stage 2: round the magnitudes; sin^2 and cos ignore the sign.
   logic [57:0] m_hlat, m_hlon, m_r1, m_r2;
   logic [32:0] hlat_ff, hlon_ff, r1_ff, r2_ff;

   always_comb begin
      m_hlat = p_hlat_ff[57] ? 58'(-p_hlat_ff) : 58'(p_hlat_ff);
      m_hlon = p_hlon_ff[57] ? 58'(-p_hlon_ff) : 58'(p_hlon_ff);
      m_r1   = p_r1_ff[57]   ? 58'(-p_r1_ff)   : 58'(p_r1_ff);
      m_r2   = p_r2_ff[57]   ? 58'(-p_r2_ff)   : 58'(p_r2_ff);
   end

   always_ff @(posedge clock) begin
      hlat_ff <= 33'((m_hlat + (58'd1 << (ANGLE_FRAC_BITS + 2))) >> (ANGLE_FRAC_BITS + 3));
      hlon_ff <= 33'((m_hlon + (58'd1 << (ANGLE_FRAC_BITS + 2))) >> (ANGLE_FRAC_BITS + 3));
      r1_ff   <= 33'((m_r1 + (58'd1 << (ANGLE_FRAC_BITS + 1))) >> (ANGLE_FRAC_BITS + 2));
      r2_ff   <= 33'((m_r2 + (58'd1 << (ANGLE_FRAC_BITS + 1))) >> (ANGLE_FRAC_BITS + 2));
   end

   // Stage 3: fold half differences into the first quadrant, clamp latitudes.
   // A half difference just past pi folds to a small negative angle.
   cval_type ang_hlat_ff, ang_hlon_ff, ang_r1_ff, ang_r2_ff;

   always_ff @(posedge clock) begin
      ang_hlat_ff <= (hlat_ff > HALF_PI_Q30) ? cval_type'(PI_Q30) - cval_type'(hlat_ff) :
                                               cval_type'(hlat_ff);
      ang_hlon_ff <= (hlon_ff > HALF_PI_Q30) ? cval_type'(PI_Q30) - cval_type'(hlon_ff) :
                                               cval_type'(hlon_ff);
      ang_r1_ff   <= cval_type'((r1_ff > HALF_PI_Q30) ? HALF_PI_Q30 : r1_ff);
      ang_r2_ff   <= cval_type'((r2_ff > HALF_PI_Q30) ? HALF_PI_Q30 : r2_ff);
   end

   // Sines of the two half differences and cosines of the two latitudes.
   cval_type sin_hlat, sin_hlon, cos_r1, cos_r2;

   gcd_cordic u_rot_hlat (
      .clock(clock), .mode(CORDIC_ROTATE),
      .x_start(GAIN_INV), .y_start('0), .z_start(ang_hlat_ff),
      .x_end(), .y_end(sin_hlat), .z_end()
   );

   gcd_cordic u_rot_hlon (
      .clock(clock), .mode(CORDIC_ROTATE),
      .x_start(GAIN_INV), .y_start('0), .z_start(ang_hlon_ff),
      .x_end(), .y_end(sin_hlon), .z_end()
   );

   gcd_cordic u_rot_r1 (
      .clock(clock), .mode(CORDIC_ROTATE),
      .x_start(GAIN_INV), .y_start('0), .z_start(ang_r1_ff),
      .x_end(cos_r1), .y_end(), .z_end()
   );

   gcd_cordic u_rot_r2 (
      .clock(clock), .mode(CORDIC_ROTATE),
      .x_start(GAIN_INV), .y_start('0), .z_start(ang_r2_ff),
      .x_end(cos_r2), .y_end(), .z_end()
   );

   // Product stages 1 and 2: squares and cosine product, then rounding.
   logic signed [67:0] p_sq_lat_ff, p_sq_lon_ff, p_cc_ff;
   cval_type           sq_lat_ff, sq_lon_ff, cc_ff;

   always_ff @(posedge clock) begin
      p_sq_lat_ff <= 68'(sin_hlat) * 68'(sin_hlat);
      p_sq_lon_ff <= 68'(sin_hlon) * 68'(sin_hlon);
      p_cc_ff     <= 68'(cos_r1) * 68'(cos_r2);
      sq_lat_ff   <= rnd_q30(p_sq_lat_ff);
      sq_lon_ff   <= rnd_q30(p_sq_lon_ff);
      cc_ff       <= rnd_q30(p_cc_ff);
   end

   // Product stages 3 and 4: weight the longitude term, sum and clamp to [0,1].
   logic signed [67:0] p_w_ff;
   cval_type           sq_lat_d_ff, a_sum;
   logic [Q_FRAC:0]    a_ff, b_val;

   assign a_sum = sq_lat_d_ff + rnd_q30(p_w_ff);

   always_ff @(posedge clock) begin
      p_w_ff      <= 68'(cc_ff) * 68'(sq_lon_ff);
      sq_lat_d_ff <= sq_lat_ff;
      if (a_sum[CW-1]) begin
         a_ff <= '0;
      end else if (a_sum > cval_type'(ONE_Q30)) begin
         a_ff <= ONE_Q30;
      end else begin
         a_ff <= a_sum[Q_FRAC:0];
      end
   end

   assign b_val = ONE_Q30 - a_ff;

   // Square roots of a and 1-a.
   logic [Q_FRAC:0] sqrt_a, sqrt_b;

   gcd_sqrt u_sqrt_a (.clock(clock), .value(a_ff),  .root(sqrt_a));
   gcd_sqrt u_sqrt_b (.clock(clock), .value(b_val), .root(sqrt_b));

   // Central half-angle by atan2.
   cval_type half_ang;

   gcd_cordic u_vec (
      .clock(clock), .mode(CORDIC_VECTOR),
      .x_start(cval_type'(sqrt_b)), .y_start(cval_type'(sqrt_a)), .z_start('0),
      .x_end(), .y_end(), .z_end(half_ang)
   );

   // Scale by twice the radius, round and saturate.
   logic [CW-2:0] ang_pos;
   logic [57:0]   dist_p_ff;
   logic [28:0]   dist_rnd;
   logic [24:0]   span_ff;

   assign ang_pos  = half_ang[CW-1] ? '0 : half_ang[CW-2:0];
   assign dist_rnd = 29'((dist_p_ff + (58'd1 << (Q_FRAC - 2))) >> (Q_FRAC - 1));

   always_ff @(posedge clock) begin
      dist_p_ff <= 58'(ang_pos) * 58'(radius_ff);
      span_ff   <= (dist_rnd > 29'(SPAN_MAX)) ? SPAN_MAX : dist_rnd[24:0];
   end

   assign rsp_valid  = valid_ff[PIPE_LAT-1];
   assign rsp_span_m = span_ff;

endmodule

`default_nettype wire

// ===== rtl/gcd_checker.sv =====
// Port-level checker for the great-circle distance unit, bound to its top level.
`default_nettype none

`include "great_circle_distance_assert.svh"

module gcd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import gcd_pkg::*;

   // Every accepted item gives one result after the fixed latency.
   `GCD_ASSERT_IMP(a_item_to_result, clock, reset, start && !busy, ##PIPE_LAT rsp_valid)

   // Every result traces back to an item accepted at the fixed latency.
   `GCD_ASSERT_IMP(a_result_from_item, clock, reset, rsp_valid, $past(start && !busy, PIPE_LAT))

   // Reset leaves no result in flight.
   `GCD_ASSERT_NXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid)

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the pipelined great-circle distance unit.
`default_nettype none

module testbench;
   import gcd_pkg::*;

   typedef struct packed {
      logic signed [27:0] src_lat;
      logic signed [28:0] src_lon;
      logic signed [27:0] dst_lat;
      logic signed [28:0] dst_lon;
   } point_pair_type;

   localparam longint LAT_SPAN = 94371840;
   localparam longint LON_SPAN = 188743680;
   localparam longint Q_ONE    = 64'sd1 << 30;
   localparam longint Q_HPI    = 64'sd1686629713;
   localparam longint Q_PI     = 64'sd3373259426;
   localparam longint K_DEG    = 64'sd74961321;
   localparam longint K_GAIN   = 64'sd652032874;
   localparam int     SETTLE   = PIPE_LAT + 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [27:0] req_src_lat = '0;
   logic signed [28:0] req_src_lon = '0;
   logic signed [27:0] req_dst_lat = '0;
   logic signed [28:0] req_dst_lon = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [23:0] csr_wdata = '0;
   logic rsp_valid;
   logic [24:0] rsp_span_m;

   point_pair_type pair_q[$];
   logic [24:0]    span_q[$];
   logic [23:0]    radius_now = 24'd6378000;
   int             errors = 0;
   int             gap_left = 0;
   bit             quiet = 1'b0;

   great_circle_distance i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_src_lat(req_src_lat), .req_src_lon(req_src_lon),
      .req_dst_lat(req_dst_lat), .req_dst_lon(req_dst_lon),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_span_m(rsp_span_m)
   );

   // Clock with a 10-unit period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rounding right shift, half away from zero.
   function automatic longint round_shift(input longint v, input int s);
      longint h;
      h = 64'sd1 << (s - 1);
      if (v >= 0) return (v + h) >>> s;
      return -((-v + h) >>> s);
   endfunction

   function automatic longint arctan_step(input int i);
      if (i < 10) return longint'(ATAN_HEAD[i]);
      if (i <= 30) return 64'sd1 << (30 - i);
      return 0;
   endfunction

   // Rotation-mode CORDIC; returns sine and cosine in Q30.
   function automatic void rotate(input longint ang, output longint sn, output longint cs);
      longint x, y, z, dx, dy;
      x = K_GAIN;
      y = 0;
      z = ang;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      sn = y;
      cs = x;
   endfunction

   // Vectoring-mode CORDIC for atan2 with both inputs non-negative.
   function automatic longint arctan2(input longint y, input longint x);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += arctan_step(i);
         end else begin
            x -= dx; y += dy; z -= arctan_step(i);
         end
      end
      return z;
   endfunction

   function automatic longint root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // sin^2 of a half difference, folded into [0, pi/2].
   function automatic longint half_sin_sq(input longint x);
      longint sn, cs;
      if (x < 0) x = -x;
      if (x > Q_HPI) x = Q_PI - x;
      rotate(x, sn, cs);
      return round_shift(sn * sn, 30);
   endfunction

   function automatic longint lat_cosine(input longint x);
      longint sn, cs;
      if (x < 0) x = -x;
      if (x > Q_HPI) x = Q_HPI;
      rotate(x, sn, cs);
      return cs;
   endfunction

   // Expected distance in meters for one point pair and radius.
   function automatic logic [24:0] span_for(input point_pair_type p, input logic [23:0] rad);
      longint lat1, lon1, lat2, lon2, hlat, hlon, cc, hav, sa, sb, ang, meters;
      lat1 = clip(longint'(p.src_lat), -LAT_SPAN, LAT_SPAN);
      lon1 = clip(longint'(p.src_lon), -LON_SPAN, LON_SPAN);
      lat2 = clip(longint'(p.dst_lat), -LAT_SPAN, LAT_SPAN);
      lon2 = clip(longint'(p.dst_lon), -LON_SPAN, LON_SPAN);
      hlat = round_shift((lat2 - lat1) * K_DEG, ANGLE_FRAC_BITS + 3);
      hlon = round_shift((lon2 - lon1) * K_DEG, ANGLE_FRAC_BITS + 3);
      cc = round_shift(lat_cosine(round_shift(lat1 * K_DEG, ANGLE_FRAC_BITS + 2)) *
                       lat_cosine(round_shift(lat2 * K_DEG, ANGLE_FRAC_BITS + 2)), 30);
      hav = half_sin_sq(hlat) + round_shift(cc * half_sin_sq(hlon), 30);
      hav = clip(hav, 0, Q_ONE);
      sa = root_floor(longint'(hav) << 30);
      sb = root_floor(longint'(Q_ONE - hav) << 30);
      ang = arctan2(sa, sb);
      if (ang < 0) ang = 0;
      meters = round_shift(2 * ang * longint'(rad), 30);
      return 25'(clip(meters, 0, 33554431));
   endfunction

   task automatic report(input string what);
      $display("%0t: %s", $realtime, what);
      errors++;
   endtask

   // Driver: presents queued items at the falling edge with random gaps unless quiet is set.
   always @(negedge clock) begin
      bit go;
      go = 1'b0;
      if (!reset && pair_q.size() != 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
         end else begin
            go = 1'b1;
         end
      end
      start <= go;
      if (go) begin
         req_src_lat <= pair_q[0].src_lat;
         req_src_lon <= pair_q[0].src_lon;
         req_dst_lat <= pair_q[0].dst_lat;
         req_dst_lon <= pair_q[0].dst_lon;
      end
   end

   // Monitor: records accepted items and checks each result strobe.
   always @(posedge clock) begin
      point_pair_type p;
      logic [24:0] want;
      if (!reset) begin
         if (start && !busy) begin
            p = '{req_src_lat, req_src_lon, req_dst_lat, req_dst_lon};
            span_q.push_back(span_for(p, radius_now));
            void'(pair_q.pop_front());
         end
         if (rsp_valid) begin
            if (span_q.size() == 0) begin
               report($sformatf("unexpected result span_m=%0d", rsp_span_m));
            end else begin
               want = span_q.pop_front();
               if (rsp_span_m !== want)
                  report($sformatf("span_m got %0d want %0d", rsp_span_m, want));
            end
         end
      end
   end

   function automatic point_pair_type any_pair(input bit raw);
      point_pair_type p;
      if (raw) begin
         p.src_lat = 28'($urandom);
         p.src_lon = 29'($urandom);
         p.dst_lat = 28'($urandom);
         p.dst_lon = 29'($urandom);
      end else begin
         p.src_lat = 28'(longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN);
         p.src_lon = 29'(longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN);
         p.dst_lat = 28'(longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN);
         p.dst_lon = 29'(longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN);
      end
      return p;
   endfunction

   task automatic push_pair(input longint a, input longint b, input longint c,
                            input longint d);
      pair_q.push_back('{28'(a), 29'(b), 28'(c), 29'(d)});
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         pair_q.push_back(any_pair($urandom_range(0, 3) == 0));
   endtask

   // Waits for the pipeline to drain before touching the radius.
   task automatic drain();
      wait (pair_q.size() == 0 && span_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_radius(input logic [23:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      radius_now = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Stimulus phases.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pairs under the reset radius.
      push_pair(0, 0, 0, 0);
      push_pair(LAT_SPAN, 0, -LAT_SPAN, 0);
      push_pair(0, -LON_SPAN, 0, LON_SPAN);
      push_pair(0, 0, 0, LON_SPAN);
      push_pair(LAT_SPAN, LON_SPAN, LAT_SPAN, -LON_SPAN);
      push_pair(-LAT_SPAN, 0, -LAT_SPAN, 12345);
      push_pair(1, 0, 0, 0);
      push_pair(0, -1, 0, 1);
      push_pair(-LAT_SPAN, -LON_SPAN, LAT_SPAN, LON_SPAN);
      // Out of range coordinates saturate.
      push_pair(28'sh7FFFFFF, 29'sh0FFFFFFF, 28'sh8000000, 29'sh10000000);
      push_pair(LAT_SPAN + 1, LON_SPAN + 1, -LAT_SPAN - 1, -LON_SPAN - 1);
      push_pair(-1, -1, -1, -1);
      // Half differences past a quarter turn.
      push_pair(10 << 20, -170 << 20, -10 << 20, 170 << 20);
      push_pair(45 << 20, 0, -45 << 20, 180 << 20);
      push_pair(60 << 20, 100 << 20, 60 << 20, -100 << 20);
      push_pair(LAT_SPAN - 1, 5, LAT_SPAN, -5);
      queue_random(4);
      drain();

      // Zero radius gives zero distance.
      write_radius(24'd0);
      push_pair(-LAT_SPAN, -LON_SPAN, LAT_SPAN, LON_SPAN);
      queue_random(40);
      drain();

      // Largest radius drives the result into saturation.
      write_radius(24'hFFFFFF);
      push_pair(LAT_SPAN, 0, -LAT_SPAN, 0);
      queue_random(200);
      drain();

      write_radius(24'd1);
      queue_random(100);
      drain();

      write_radius(24'd10000000);
      queue_random(250);
      drain();

      write_radius(24'($urandom_range(1, 10000000)));
      queue_random(250);
      drain();

      // Final stretch without gaps.
      write_radius(24'd6371000);
      quiet = 1'b1;
      queue_random(240);
      drain();

      if (errors == 0) begin
         $display("great_circle_distance: match");
      end else begin
         $display("great_circle_distance: mismatch");
      end
      $finish;
   end

   // Timeout.
   initial begin
      #5000000;
      $display("great_circle_distance: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_cordic.sv
rtl/gcd_sqrt.sv
rtl/great_circle_distance.sv
rtl/gcd_checker.sv
tb/testbench.sv
